// ===== rtl/core/bsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear surface interpolator package
// Shared widths, operation codes, extrapolation modes and a saturation helper.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int MAX_X_NODES = 16;
  localparam int MAX_Y_NODES = 16;
  localparam int XIDX_W      = $clog2(MAX_X_NODES);
  localparam int YIDX_W      = $clog2(MAX_Y_NODES);
  localparam int ZADDR_W     = XIDX_W + YIDX_W;
  localparam int CNT_W       = 5;

  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int NUM_W       = DIFF_W + 16;
  localparam int MULB_W      = 17;
  localparam int PROD_W      = DIFF_W + MULB_W;
  localparam int ACC_W       = PROD_W + 16;
  localparam int RND_W       = ACC_W - 16;
  localparam int SUM_W       = RND_W + 1;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_WR_X  = 2'd1;
  localparam logic [1:0] OP_WR_Y  = 2'd2;
  localparam logic [1:0] OP_WR_Z  = 2'd3;

  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_FLAT  = 2'd1;
  localparam logic [1:0] MODE_BILIN = 2'd2;

  localparam logic [1:0] CFG_X_COUNT = 2'd0;
  localparam logic [1:0] CFG_Y_COUNT = 2'd1;
  localparam logic [1:0] CFG_EXTRAP  = 2'd2;

  typedef logic signed [DATA_W-1:0] q16_t;

  function automatic q16_t sat_sum(input logic signed [SUM_W-1:0] v);
    q16_t r;
    if (v > SUM_W'(signed'(32'sh7FFFFFFF))) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -SUM_W'(64'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bsi_div.sv =====
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module bsi_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [bsi_pkg::NUM_W-1:0]     num,
  input  logic signed [bsi_pkg::DIFF_W-1:0]    den,
  output logic                                 busy,
  output logic                                 done,
  output bsi_pkg::q16_t                        quo
);
  import bsi_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0]  n_r;
  logic [DIFF_W:0]   rem_r;
  logic [DIFF_W-1:0] d_r;
  logic [CW-1:0]     cnt_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [DIFF_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[DIFF_W-1:0], n_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        n_r    <= num[NUM_W-1] ? NUM_W'(-num) : num;
        d_r    <= den[DIFF_W-1] ? DIFF_W'(-den) : den;
        neg_r  <= num[NUM_W-1] ^ den[DIFF_W-1];
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
        n_r   <= {n_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      quo = (n_r > NUM_W'(64'h80000000)) ? 32'sh80000000 : DATA_W'(-n_r);
    end else begin
      quo = (n_r > NUM_W'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : n_r[DATA_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider busy after completion");
`endif

endmodule

// ===== rtl/core/bsi_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 17 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module bsi_mul (
  input  logic                                 clk,
  input  logic signed [bsi_pkg::DIFF_W-1:0]    mul_a,
  input  logic signed [bsi_pkg::MULB_W-1:0]    mul_b,
  output logic signed [bsi_pkg::PROD_W-1:0]    prod
);
  import bsi_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/bilinear_surface_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Bilinear surface interpolator
// Node and grid stores, a search and interpolation sequencer, a shared
// serial divider and a shared multiplier.
// ----------------------------------------------------------------------------
// A load transaction is taken while the unit is idle. A query first runs the
// two node searches and then decides. In bilinear mode each axis with more
// than one node then fetches its bracketing nodes and runs the shared serial
// divider, after which the four grid reads and the three interpolations on
// the shared multiplier follow; an axis with a single node or equal
// neighbouring nodes skips its division. A flat answer reads a single grid
// value after the searches and a zero answer reads none. No new transaction
// is taken while a query is under way.
module bilinear_surface_interpolator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [3:0]          in_row,
  input  logic [3:0]          in_col,
  input  logic signed [31:0]  in_value,
  input  logic signed [31:0]  in_query_x,
  input  logic signed [31:0]  in_query_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_z_value,
  output logic                out_outside_range
);
  import bsi_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SRA  = 5'd1;
  localparam logic [4:0] ST_SRB  = 5'd2;
  localparam logic [4:0] ST_DEC  = 5'd3;
  localparam logic [4:0] ST_FCHK = 5'd4;
  localparam logic [4:0] ST_FLA  = 5'd5;
  localparam logic [4:0] ST_FLB  = 5'd6;
  localparam logic [4:0] ST_FHA  = 5'd7;
  localparam logic [4:0] ST_FHB  = 5'd8;
  localparam logic [4:0] ST_DIV  = 5'd9;
  localparam logic [4:0] ST_ZA   = 5'd10;
  localparam logic [4:0] ST_ZB   = 5'd11;
  localparam logic [4:0] ST_LSET = 5'd12;
  localparam logic [4:0] ST_M1   = 5'd13;
  localparam logic [4:0] ST_M2   = 5'd14;
  localparam logic [4:0] ST_M3   = 5'd15;
  localparam logic [4:0] ST_FIN  = 5'd16;
  localparam logic [4:0] ST_OUT  = 5'd17;

  logic [4:0] state_r;

  logic [CNT_W-1:0] x_count_r;
  logic [CNT_W-1:0] y_count_r;
  logic [1:0]       mode_r;

  q16_t x_mem [MAX_X_NODES];
  q16_t y_mem [MAX_Y_NODES];
  q16_t z_mem [MAX_X_NODES*MAX_Y_NODES];
  q16_t x_rd_r;
  q16_t y_rd_r;
  q16_t z_rd_r;

  q16_t       qx_r;
  q16_t       qy_r;
  logic [3:0] nxm1_r;
  logic [3:0] nym1_r;
  logic       axis_r;
  logic [3:0] k_r;
  logic [3:0] i_r;
  logic [3:0] j_r;
  logic       le0_x_r, ge_x_r, out_x_r;
  logic       le0_y_r, ge_y_r, out_y_r;
  logic       outside_r;
  logic       flat_r;
  q16_t       lo_r;
  q16_t       fx_r;
  q16_t       fy_r;
  logic [1:0] zk_r;
  q16_t       zv_r [4];
  logic [1:0] lsel_r;
  q16_t       la_r;
  logic signed [DIFF_W-1:0] d_r;
  q16_t       lf_r;
  logic signed [PROD_W-1:0] pl_r;
  logic signed [RND_W-1:0]  rnd_r;
  q16_t       r0_r;
  q16_t       r1_r;
  q16_t       res_z_r;
  logic       out_valid_r;
  q16_t       out_z_r;
  logic       out_o_r;

  logic       in_acc;
  logic [3:0] n_addr;
  q16_t       nd;
  q16_t       cc;
  logic [3:0] nm1;
  logic [3:0] z_row;
  logic [3:0] z_col;
  logic       div_start;
  logic signed [DIFF_W-1:0] df_num;
  logic signed [DIFF_W-1:0] df_den;
  logic       div_busy;
  logic       div_done;
  q16_t       div_q;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  acc;
  q16_t       z01e, z10e, z11e, op_a, op_b;
  logic       nx_gt1, ny_gt1;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign nd  = axis_r ? y_rd_r : x_rd_r;
  assign cc  = axis_r ? qy_r : qx_r;
  assign nm1 = axis_r ? nym1_r : nxm1_r;

  always_comb begin
    case (state_r)
      ST_FLA:  n_addr = axis_r ? j_r : i_r;
      ST_FHA:  n_addr = (axis_r ? j_r : i_r) + 4'd1;
      default: n_addr = k_r;
    endcase
  end

  assign z_row = j_r + {3'b0, zk_r[1]};
  assign z_col = i_r + {3'b0, zk_r[0]};

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_WR_X) begin
      x_mem[in_col] <= in_value;
    end
    if (in_acc && in_op == OP_WR_Y) begin
      y_mem[in_row] <= in_value;
    end
    if (in_acc && in_op == OP_WR_Z) begin
      z_mem[{in_row, in_col}] <= in_value;
    end
    x_rd_r <= x_mem[n_addr];
    y_rd_r <= y_mem[n_addr];
    z_rd_r <= z_mem[{z_row, z_col}];
  end

  function automatic logic [3:0] use_m1(input logic [CNT_W-1:0] c, input int maxn);
    logic [3:0] r;
    if (c == '0) begin
      r = 4'd0;
    end else if (c > CNT_W'(maxn)) begin
      r = 4'(maxn - 1);
    end else begin
      r = 4'(c - 1'b1);
    end
    return r;
  endfunction

  assign nx_gt1 = (nxm1_r != 4'd0);
  assign ny_gt1 = (nym1_r != 4'd0);

  always_comb begin
    z01e = nx_gt1 ? zv_r[1] : zv_r[0];
    z10e = ny_gt1 ? zv_r[2] : zv_r[0];
    if (nx_gt1 && ny_gt1) begin
      z11e = zv_r[3];
    end else if (ny_gt1) begin
      z11e = zv_r[2];
    end else begin
      z11e = z01e;
    end
    case (lsel_r)
      2'd0: begin
        op_a = zv_r[0];
        op_b = z01e;
      end
      2'd1: begin
        op_a = z10e;
        op_b = z11e;
      end
      default: begin
        op_a = r0_r;
        op_b = r1_r;
      end
    endcase
  end

  assign df_num    = DIFF_W'(cc) - DIFF_W'(lo_r);
  assign df_den    = DIFF_W'(nd) - DIFF_W'(lo_r);
  assign div_start = (state_r == ST_FHB) && (df_den != '0);

  bsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({df_num, 16'b0}),
    .den   (df_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign mul_b = (state_r == ST_M1) ? {1'b0, lf_r[15:0]} : {lf_r[31], lf_r[31:16]};

  bsi_mul u_mul (
    .clk   (clk),
    .mul_a (d_r),
    .mul_b (mul_b),
    .prod  (mul_p)
  );

  assign acc = {mul_p, 16'b0} + ACC_W'(pl_r) + ACC_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_count_r   <= CNT_W'(2);
      y_count_r   <= CNT_W'(2);
      mode_r      <= MODE_BILIN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_X_COUNT: x_count_r <= cfg_wdata;
          CFG_Y_COUNT: y_count_r <= cfg_wdata;
          CFG_EXTRAP:  mode_r    <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_op == OP_QUERY) begin
            qx_r    <= in_query_x;
            qy_r    <= in_query_y;
            nxm1_r  <= use_m1(x_count_r, MAX_X_NODES);
            nym1_r  <= use_m1(y_count_r, MAX_Y_NODES);
            axis_r  <= 1'b0;
            k_r     <= 4'd0;
            i_r     <= 4'd0;
            j_r     <= 4'd0;
            state_r <= ST_SRA;
          end
        end
        ST_SRA: state_r <= ST_SRB;
        ST_SRB: begin
          if (k_r < nm1 && nd <= cc) begin
            if (axis_r) begin
              j_r <= k_r;
            end else begin
              i_r <= k_r;
            end
          end
          if (k_r == 4'd0) begin
            if (axis_r) begin
              le0_y_r <= (cc <= nd);
              out_y_r <= (cc < nd) || ((k_r == nm1) && (cc > nd));
            end else begin
              le0_x_r <= (cc <= nd);
              out_x_r <= (cc < nd) || ((k_r == nm1) && (cc > nd));
            end
          end
          if (k_r == nm1) begin
            if (axis_r) begin
              ge_y_r <= (cc >= nd);
              if (cc > nd && k_r != 4'd0) out_y_r <= 1'b1;
              state_r <= ST_DEC;
            end else begin
              ge_x_r <= (cc >= nd);
              if (cc > nd && k_r != 4'd0) out_x_r <= 1'b1;
              axis_r  <= 1'b1;
              k_r     <= 4'd0;
              state_r <= ST_SRA;
            end
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= ST_SRA;
          end
        end
        ST_DEC: begin
          outside_r <= out_x_r || out_y_r;
          flat_r    <= (out_x_r || out_y_r) && mode_r == MODE_FLAT;
          zk_r      <= 2'd0;
          axis_r    <= 1'b0;
          if ((out_x_r || out_y_r) && mode_r == MODE_ZERO) begin
            res_z_r <= '0;
            state_r <= ST_OUT;
          end else if ((out_x_r || out_y_r) && mode_r == MODE_FLAT) begin
            if (ge_x_r) begin
              i_r <= nxm1_r;
            end else if (le0_x_r) begin
              i_r <= 4'd0;
            end
            if (ge_y_r) begin
              j_r <= nym1_r;
            end else if (le0_y_r) begin
              j_r <= 4'd0;
            end
            state_r <= ST_ZA;
          end else begin
            state_r <= ST_FCHK;
          end
        end
        ST_FCHK: begin
          if (nm1 == 4'd0) begin
            if (axis_r) begin
              fy_r    <= '0;
              state_r <= ST_ZA;
            end else begin
              fx_r    <= '0;
              axis_r  <= 1'b1;
            end
          end else begin
            state_r <= ST_FLA;
          end
        end
        ST_FLA: state_r <= ST_FLB;
        ST_FLB: begin
          lo_r    <= nd;
          state_r <= ST_FHA;
        end
        ST_FHA: state_r <= ST_FHB;
        ST_FHB: begin
          if (df_den == '0) begin
            if (axis_r) begin
              fy_r    <= '0;
              state_r <= ST_ZA;
            end else begin
              fx_r    <= '0;
              axis_r  <= 1'b1;
              state_r <= ST_FCHK;
            end
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (axis_r) begin
              fy_r    <= div_q;
              state_r <= ST_ZA;
            end else begin
              fx_r    <= div_q;
              axis_r  <= 1'b1;
              state_r <= ST_FCHK;
            end
          end
        end
        ST_ZA: state_r <= ST_ZB;
        ST_ZB: begin
          zv_r[zk_r] <= z_rd_r;
          if (flat_r) begin
            res_z_r <= z_rd_r;
            state_r <= ST_OUT;
          end else if (zk_r == 2'd3) begin
            lsel_r  <= 2'd0;
            state_r <= ST_LSET;
          end else begin
            zk_r    <= zk_r + 2'd1;
            state_r <= ST_ZA;
          end
        end
        ST_LSET: begin
          la_r    <= op_a;
          d_r     <= DIFF_W'(op_b) - DIFF_W'(op_a);
          lf_r    <= (lsel_r == 2'd2) ? fy_r : fx_r;
          state_r <= ST_M1;
        end
        ST_M1: state_r <= ST_M2;
        ST_M2: begin
          pl_r    <= mul_p;
          state_r <= ST_M3;
        end
        ST_M3: begin
          rnd_r   <= acc[ACC_W-1:16];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          case (lsel_r)
            2'd0: begin
              r0_r    <= sat_sum(SUM_W'(la_r) + SUM_W'(rnd_r));
              lsel_r  <= 2'd1;
              state_r <= ST_LSET;
            end
            2'd1: begin
              r1_r    <= sat_sum(SUM_W'(la_r) + SUM_W'(rnd_r));
              lsel_r  <= 2'd2;
              state_r <= ST_LSET;
            end
            default: begin
              res_z_r <= sat_sum(SUM_W'(la_r) + SUM_W'(rnd_r));
              state_r <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_z_r <= res_z_r;
            out_o_r <= outside_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_z_value       = out_z_r;
  assign out_outside_range = out_o_r;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_DIV)) else $error("divider running outside its step");
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT)) else $error("stray result");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |-> (i_r <= nxm1_r && j_r <= nym1_r))
    else $error("search index beyond node range");
`endif

endmodule

// ===== bench/bilinear_surface_interpolator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear surface interpolator testbench
// Loads the node and grid stores, then runs directed and random query phases
// under several count and extrapolation settings. A scoreboard predicts each
// query answer in 64-bit arithmetic and checks every result transaction.
// ----------------------------------------------------------------------------
module bilinear_surface_interpolator_unit_tb;
  import bsi_pkg::*;

  typedef struct {
    q16_t z;
    logic outside;
  } surf_answer_t;

  class surface_scoreboard;
    q16_t          x_nodes [MAX_X_NODES];
    q16_t          y_nodes [MAX_Y_NODES];
    q16_t          z_grid  [MAX_Y_NODES][MAX_X_NODES];
    logic [4:0]    x_count = 5'd2;
    logic [4:0]    y_count = 5'd2;
    logic [1:0]    mode    = MODE_BILIN;
    surf_answer_t  answers [$];
    int            errors;
    int            queries;
    int            results;
    int            outside_seen;

    function automatic q16_t sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return q16_t'(v);
    endfunction

    function automatic int nodes_used(logic [4:0] c, int maxn);
      if (c == 0) return 1;
      if (c > maxn) return maxn;
      return c;
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
      longint d;
      d = (b - a) * f;
      return sat(a + ((d + 32768) >>> 16));
    endfunction

    function automatic longint fraction(longint c, longint lo, longint hi);
      if (hi == lo) return 0;
      return sat(((c - lo) * 65536) / (hi - lo));
    endfunction

    function void note_input(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                             q16_t value, q16_t qx, q16_t qy);
      int nx, ny, i, j, k;
      bit ex, ey;
      longint fx, fy, z00, z01, z10, z11, r0, r1, zz;
      surf_answer_t a;
      case (op)
        OP_WR_X: x_nodes[col] = value;
        OP_WR_Y: y_nodes[row] = value;
        OP_WR_Z: z_grid[row][col] = value;
        default: begin
          nx = nodes_used(x_count, MAX_X_NODES);
          ny = nodes_used(y_count, MAX_Y_NODES);
          i = 0;
          j = 0;
          for (k = 0; k <= nx - 2; k++) if (x_nodes[k] <= qx) i = k;
          for (k = 0; k <= ny - 2; k++) if (y_nodes[k] <= qy) j = k;
          ex = (qx < x_nodes[0]) || (qx > x_nodes[nx-1]);
          ey = (qy < y_nodes[0]) || (qy > y_nodes[ny-1]);
          a.outside = ex || ey;
          if (a.outside && mode == MODE_ZERO) begin
            zz = 0;
          end else if (a.outside && mode == MODE_FLAT) begin
            if (qx <= x_nodes[0]) i = 0;
            if (qx >= x_nodes[nx-1]) i = nx - 1;
            if (qy <= y_nodes[0]) j = 0;
            if (qy >= y_nodes[ny-1]) j = ny - 1;
            zz = z_grid[j][i];
          end else begin
            fx = 0;
            fy = 0;
            z00 = z_grid[j][i];
            z01 = z00;
            z10 = z00;
            z11 = z00;
            if (nx > 1) begin
              fx = fraction(qx, x_nodes[i], x_nodes[i+1]);
              z01 = z_grid[j][i+1];
              z11 = z01;
            end
            if (ny > 1) begin
              fy = fraction(qy, y_nodes[j], y_nodes[j+1]);
              z10 = z_grid[j+1][i];
              z11 = (nx > 1) ? z_grid[j+1][i+1] : z10;
            end
            r0 = blend(z00, z01, fx);
            r1 = blend(z10, z11, fx);
            zz = blend(r0, r1, fy);
          end
          a.z = q16_t'(zz);
          answers.push_back(a);
          queries++;
          if (a.outside) outside_seen++;
        end
      endcase
    endfunction

    function void check_result(q16_t z, logic outside);
      surf_answer_t a;
      results++;
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result z=%h outside=%b", z, outside);
        return;
      end
      a = answers.pop_front();
      if (z !== a.z || outside !== a.outside) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected z=%h outside=%b, got z=%h outside=%b",
                   a.z, a.outside, z, outside);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_X_COUNT;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_QUERY;
  logic [3:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  q16_t        in_value = '0;
  q16_t        in_query_x = '0;
  q16_t        in_query_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  q16_t        out_z_value;
  logic        out_outside_range;

  surface_scoreboard sb = new();
  bit idling = 1'b1;

  bilinear_surface_interpolator_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= idling && ($urandom_range(0, 99) < 15);

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_z_value, out_outside_range);

  task automatic send(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                      q16_t value, q16_t qx, q16_t qy);
    while (idling && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_row <= row;
    in_col <= col;
    in_value <= value;
    in_query_x <= qx;
    in_query_y <= qy;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, row, col, value, qx, qy);
    @(negedge clk);
  endtask

  task automatic query(q16_t qx, q16_t qy);
    send(OP_QUERY, 4'($urandom), 4'($urandom), q16_t'($urandom), qx, qy);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (220) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_X_COUNT: sb.x_count = val;
      CFG_Y_COUNT: sb.y_count = val;
      default:     sb.mode = val[1:0];
    endcase
  endtask

  task automatic load_axis(logic [1:0] op);
    longint acc;
    int k;
    acc = longint'(q16_t'($urandom)) >>> $urandom_range(4, 14);
    for (k = 0; k < 16; k++) begin
      if (op == OP_WR_X) send(op, 4'($urandom), 4'(k), sb.sat(acc), '0, '0);
      else send(op, 4'(k), 4'($urandom), sb.sat(acc), '0, '0);
      case ($urandom_range(0, 9))
        0:       acc = acc;
        1:       acc = acc + $urandom_range(1, 32'h0100_0000);
        default: acc = acc + $urandom_range(1, 32'h0004_0000);
      endcase
    end
  endtask

  function automatic q16_t pick_coord(bit on_x);
    longint lo, hi, t;
    int n, r;
    n = on_x ? sb.nodes_used(sb.x_count, MAX_X_NODES)
             : sb.nodes_used(sb.y_count, MAX_Y_NODES);
    lo = on_x ? sb.x_nodes[0] : sb.y_nodes[0];
    hi = on_x ? sb.x_nodes[n-1] : sb.y_nodes[n-1];
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    r = $urandom_range(0, 99);
    if (r < 62) return sb.sat(lo + longint'($urandom) % (hi - lo + 1));
    if (r < 75) return on_x ? sb.x_nodes[$urandom_range(0, n-1)]
                            : sb.y_nodes[$urandom_range(0, n-1)];
    if (r < 82) return sb.sat(lo - $urandom_range(1, 32'h0003_0000));
    if (r < 89) return sb.sat(hi + $urandom_range(1, 32'h0003_0000));
    return q16_t'($urandom);
  endfunction

  task automatic run_phase(logic [4:0] xc, logic [4:0] yc, logic [1:0] md, int n_items);
    int k;
    write_reg(CFG_X_COUNT, xc);
    write_reg(CFG_Y_COUNT, yc);
    write_reg(CFG_EXTRAP, md);
    load_axis(OP_WR_X);
    load_axis(OP_WR_Y);
    for (k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 19))
        0:  send(OP_WR_X, 4'($urandom), 4'($urandom), q16_t'($urandom), '0, '0);
        1:  send(OP_WR_Y, 4'($urandom), 4'($urandom), q16_t'($urandom), '0, '0);
        2, 3: send(OP_WR_Z, 4'($urandom), 4'($urandom),
                   ($urandom_range(0, 3) == 0) ? q16_t'($urandom)
                                              : q16_t'(longint'(q16_t'($urandom)) >>> 8),
                   '0, '0);
        default: query(pick_coord(1'b1), pick_coord(1'b0));
      endcase
    end
  endtask

  initial begin
    int r, c;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Fill every store entry so no query ever reads an unwritten one.
    for (r = 0; r < 16; r++) begin
      send(OP_WR_X, '0, 4'(r), q16_t'(r <<< 16), '0, '0);
      send(OP_WR_Y, 4'(r), '0, q16_t'(r <<< 16), '0, '0);
    end
    for (r = 0; r < 16; r++)
      for (c = 0; c < 16; c++)
        send(OP_WR_Z, 4'(r), 4'(c), q16_t'(longint'(q16_t'($urandom)) >>> 6), '0, '0);

    // Directed part at the reset settings: corners, extremes, saturation and
    // degenerate node spacing.
    query(32'sh0000_8000, 32'sh0000_4000);
    query(32'sh0000_0000, 32'sh0000_0000);
    query(32'sh0001_0000, 32'sh0001_0000);
    query(32'sh7FFF_FFFF, 32'sh0000_8000);
    query(32'sh8000_0000, 32'sh8000_0000);
    query(32'sh0000_8000, 32'sh7FFF_FFFF);
    send(OP_WR_Z, 4'd0, 4'd0, 32'sh7FFF_FFFF, '0, '0);
    send(OP_WR_Z, 4'd0, 4'd1, 32'sh8000_0000, '0, '0);
    send(OP_WR_Z, 4'd1, 4'd0, 32'sh8000_0000, '0, '0);
    send(OP_WR_Z, 4'd1, 4'd1, 32'sh7FFF_FFFF, '0, '0);
    query(32'sh0000_8000, 32'sh0000_8000);
    query(32'sh0003_0000, 32'shFFFE_0000);
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    send(OP_WR_X, 4'd15, 4'd1, 32'sh0000_0000, '0, '0);
    query(32'sh0000_0000, 32'sh0000_8000);
    query(32'sh0000_0001, 32'sh0000_8000);
    send(OP_WR_Y, 4'd1, 4'd15, 32'sh8000_0000, '0, '0);
    query(32'sh0000_4000, 32'sh0000_4000);
    query(32'sh0000_4000, 32'sh8000_0000);
    send(OP_WR_X, 4'd0, 4'd1, 32'sh0001_0000, '0, '0);
    send(OP_WR_Y, 4'd1, 4'd0, 32'sh0001_0000, '0, '0);

    run_phase(5'd16, 5'd16, MODE_BILIN, 100);
    run_phase(5'd1,  5'd1,  MODE_BILIN, 70);
    run_phase(5'd0,  5'd17, MODE_FLAT,  100);
    run_phase(5'd16, 5'd31, MODE_ZERO,  100);
    run_phase(5'd5,  5'd3,  2'd3,       100);
    run_phase(5'd1,  5'd16, MODE_FLAT,  100);
    idling = 1'b0;
    run_phase(5'd16, 5'd1,  MODE_BILIN, 100);
    idling = 1'b1;
    run_phase(5'd2,  5'd2,  MODE_ZERO,  70);
    run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)), MODE_BILIN, 100);
    run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
              2'($urandom_range(0, 3)), 100);

    in_valid <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Covered %0d queries (%0d outside the node range), %0d results checked.",
             sb.queries, sb.outside_seen, sb.results);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding.", sb.answers.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
